### src/lsrm_pkg.sv
// Shared types and constants for the latency sample ring monitor.
// Holds command codes, controller states, the ring entry layout and beat widths.
// No dependencies.
package lsrm_pkg;

  localparam int unsigned TIME_W      = 64;
  localparam int unsigned REASON_W    = 5;
  localparam int unsigned THRESH_W    = 32;
  localparam int unsigned COUNTER_W   = 32;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned COUNT_OUT_W = 9;

  // Input beat: wall_value, cpu_value, wall_now, cpu_now, reason bits, pad to bytes.
  localparam int unsigned IN_DATA_W  = 264;
  // Output beat: three counts, four 64-bit values, five reason counts (41 bytes).
  localparam int unsigned OUT_DATA_W = 328;

  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 32'd100000;

  typedef enum logic [CMD_W-1:0] {
    CMD_RECORD = 2'd0,
    CMD_END    = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [REASON_W-1:0] reason;
    logic [TIME_W-1:0]   cpu;
    logic [TIME_W-1:0]   wall;
  } entry_t;

endpackage

### src/latency_sample_ring_monitor_unit.sv
// Latency sample ring monitor: overwriting sample ring in one synchronous memory,
// with a report walk that accumulates counts, sums and maxima over stored entries.
// Depends on lsrm_pkg.
//
// Throughput: record and end beats are taken one per cycle while idle; the entry is written at
// the accepting edge. A report walks min(counter, SAMPLE_DEPTH) = n entries through
// the ring's single read port, one per cycle: the result is loaded once the walk ends
// and the output register is free, and no input is taken until the result is loaded.
// Reset clears the sample counter, write pointer, threshold (to 100000), controller
// and output valid; the ring memory is not cleared.
module latency_sample_ring_monitor_unit #(
  parameter int unsigned SAMPLE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [lsrm_pkg::THRESH_W-1:0]       cfg_wr_data,   // threshold_ns
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [63:0] wall_value, [127:64] cpu_value, [191:128] wall_now,
  // [255:192] cpu_now, [260:256] reasons, [263:261] zero
  input  logic [lsrm_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [lsrm_pkg::CMD_W-1:0]          s_tuser,       // [1:0] command
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [8:0] analyzed_count, [17:9] preempted_count, [26:18] real_work_count,
  // [90:27] wall_sum, [154:91] cpu_sum, [218:155] wall_max, [282:219] cpu_max,
  // [291:283] lock_wait_count, [300:292] new_slab_count, [309:301] repair_count,
  // [318:310] overflow_count, [327:319] retry_count
  output logic [lsrm_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import lsrm_pkg::*;

  localparam int unsigned AW = $clog2(SAMPLE_DEPTH);
  localparam int unsigned CW = $clog2(SAMPLE_DEPTH + 1);
  localparam int unsigned EW = CW + COUNT_OUT_W;

  function automatic logic [COUNT_OUT_W-1:0] cnt_out(input logic [CW-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    return e[COUNT_OUT_W-1:0];
  endfunction

  // input beat fields
  logic [TIME_W-1:0]   in_wall_value, in_cpu_value, in_wall_now, in_cpu_now;
  logic [REASON_W-1:0] in_reason;
  cmd_t                in_cmd;

  assign in_wall_value = s_tdata[63:0];
  assign in_cpu_value  = s_tdata[127:64];
  assign in_wall_now   = s_tdata[191:128];
  assign in_cpu_now    = s_tdata[255:192];
  assign in_reason     = s_tdata[260:256];
  assign in_cmd        = cmd_t'(s_tuser);

  // control and state
  state_t               state, state_next;
  logic [THRESH_W-1:0]  threshold;
  logic [COUNTER_W-1:0] counter;
  logic [AW-1:0]        wr_ptr;
  logic [CW-1:0]        walk_len, idx;
  logic                 rd_vld;
  logic                 s_acc, wr_en, rd_en, load_out;

  // ring storage
  entry_t ring [SAMPLE_DEPTH];
  entry_t wr_entry, rd_q;

  // accumulators
  logic [TIME_W-1:0] wall_sum, cpu_sum, wall_max, cpu_max;
  logic [CW-1:0]     pre_cnt, real_cnt;
  logic [CW-1:0]     rsn_cnt [REASON_W];

  logic [TIME_W-1:0] wall_delta, cpu_delta;
  logic              keep_end;
  logic [TIME_W+1:0] three_cpu;
  logic              preempted;
  logic [CW-1:0]     n_lim;

  assign s_acc      = s_tvalid && s_tready;
  assign wall_delta = in_wall_now - in_wall_value;
  assign cpu_delta  = in_cpu_now - in_cpu_value;
  assign keep_end   = wall_delta >= TIME_W'(threshold);
  assign wr_en      = s_acc && ((in_cmd == CMD_RECORD) || ((in_cmd == CMD_END) && keep_end));

  always_comb begin
    wr_entry.reason = in_reason;
    if (in_cmd == CMD_RECORD) begin
      wr_entry.wall = in_wall_value;
      wr_entry.cpu  = in_cpu_value;
    end else begin
      wr_entry.wall = wall_delta;
      wr_entry.cpu  = cpu_delta;
    end
  end

  assign n_lim = (counter < COUNTER_W'(SAMPLE_DEPTH)) ? counter[CW-1:0] : CW'(SAMPLE_DEPTH);

  // exact 3*cpu in 66 bits, so no overflow case is needed
  assign three_cpu = {2'b00, rd_q.cpu} + {1'b0, rd_q.cpu, 1'b0};
  assign preempted = {2'b00, rd_q.wall} > three_cpu;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && (in_cmd == CMD_REPORT)) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        rd_en = idx < walk_len;
        if (!rd_en && !rd_vld) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // memory: one write port for record/end, one registered read port for the walk;
  // writes happen only in idle and reads only in the walk, so they never overlap
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= ring[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      counter   <= '0;
      wr_ptr    <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        threshold <= cfg_wr_data;
      end
      if (wr_en) begin
        counter <= counter + 1'b1;
        // the slot follows the counter, which restarts at zero when it wraps
        if ((wr_ptr == AW'(SAMPLE_DEPTH - 1)) || (counter == '1)) begin
          wr_ptr <= '0;
        end else begin
          wr_ptr <= wr_ptr + 1'b1;
        end
      end
      rd_vld <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && (in_cmd == CMD_REPORT)) begin
      walk_len <= n_lim;
      idx      <= '0;
      wall_sum <= '0;
      cpu_sum  <= '0;
      wall_max <= '0;
      cpu_max  <= '0;
      pre_cnt  <= '0;
      real_cnt <= '0;
      for (int b = 0; b < REASON_W; b++) begin
        rsn_cnt[b] <= '0;
      end
    end else begin
      if (rd_en) begin
        idx <= idx + 1'b1;
      end
      if (rd_vld) begin
        wall_sum <= wall_sum + rd_q.wall;
        cpu_sum  <= cpu_sum + rd_q.cpu;
        if (rd_q.wall > wall_max) begin
          wall_max <= rd_q.wall;
        end
        if (rd_q.cpu > cpu_max) begin
          cpu_max <= rd_q.cpu;
        end
        if (preempted) begin
          pre_cnt <= pre_cnt + 1'b1;
        end else begin
          real_cnt <= real_cnt + 1'b1;
        end
        for (int b = 0; b < REASON_W; b++) begin
          if (rd_q.reason[b]) begin
            rsn_cnt[b] <= rsn_cnt[b] + 1'b1;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {cnt_out(rsn_cnt[4]), cnt_out(rsn_cnt[3]), cnt_out(rsn_cnt[2]),
                  cnt_out(rsn_cnt[1]), cnt_out(rsn_cnt[0]),
                  cpu_max, wall_max, cpu_sum, wall_sum,
                  cnt_out(real_cnt), cnt_out(pre_cnt), cnt_out(walk_len)};
    end
  end

  // checks
  a_ptr_tracks_counter: assert property (@(posedge clk) disable iff (rst)
    (counter < COUNTER_W'(SAMPLE_DEPTH)) |-> (AW'(counter) == wr_ptr))
    else $error("write pointer out of step with sample counter");

  a_read_only_in_walk: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == ST_WALK))
    else $error("read data returned outside the walk");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending beat");

  a_walk_counts_add_up: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (CW'(pre_cnt + real_cnt) == walk_len))
    else $error("preempted and real-work counts do not cover the walk");

endmodule

### sim/tb_latency_sample_ring_monitor_unit.sv
`timescale 1ns / 100ps
// Testbench for latency_sample_ring_monitor_unit: directed and random command beats
// drive the sample ring, and each report beat is checked against an in-bench model.
// Depends on lsrm_pkg and the unit itself.
module tb_latency_sample_ring_monitor_unit;
  import lsrm_pkg::*;

  localparam int unsigned RING_DEPTH = 256;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // largest CPU time whose triple still fits in 64 bits
  localparam logic [TIME_W-1:0] CPU_TRIPLE_LIMIT = 64'h5555_5555_5555_5555;
  localparam logic [TIME_W-1:0] TIME_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int unsigned ITEMS_PER_PHASE = 670;
  localparam int unsigned WALK_SETTLE = RING_DEPTH + 8;

  typedef struct packed {
    logic [2:0]          pad;
    logic [REASON_W-1:0] reasons;
    logic [TIME_W-1:0]   cpu_now;
    logic [TIME_W-1:0]   wall_now;
    logic [TIME_W-1:0]   cpu_value;
    logic [TIME_W-1:0]   wall_value;
  } cmd_payload_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    cmd_payload_t     data;
  } cmd_beat_t;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] retry;
    logic [COUNT_OUT_W-1:0] overflow;
    logic [COUNT_OUT_W-1:0] repair;
    logic [COUNT_OUT_W-1:0] new_slab;
    logic [COUNT_OUT_W-1:0] lock_wait;
    logic [TIME_W-1:0]      cpu_max;
    logic [TIME_W-1:0]      wall_max;
    logic [TIME_W-1:0]      cpu_sum;
    logic [TIME_W-1:0]      wall_sum;
    logic [COUNT_OUT_W-1:0] real_work;
    logic [COUNT_OUT_W-1:0] preempted;
    logic [COUNT_OUT_W-1:0] analyzed;
  } report_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [THRESH_W-1:0]    cfg_wr_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic [CMD_W-1:0]       s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;

  latency_sample_ring_monitor_unit #(
    .SAMPLE_DEPTH(RING_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // ring model
  logic [TIME_W-1:0]    ring_wall [RING_DEPTH];
  logic [TIME_W-1:0]    ring_cpu [RING_DEPTH];
  logic [REASON_W-1:0]  ring_reason [RING_DEPTH];
  logic [COUNTER_W-1:0] stored_total = '0;
  logic [THRESH_W-1:0]  threshold = THRESHOLD_RESET;

  cmd_beat_t   cmd_queue[$];
  report_t     expected_reports[$];
  int unsigned pushed_count = 0;
  int unsigned accepted_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 600000);
    $display("tb_latency_sample_ring_monitor_unit: errors");
    $finish;
  end

  task automatic store_sample(input logic [TIME_W-1:0] w, input logic [TIME_W-1:0] c,
                              input logic [REASON_W-1:0] r);
    int unsigned slot;
    slot = stored_total % RING_DEPTH;
    ring_wall[slot] = w;
    ring_cpu[slot] = c;
    ring_reason[slot] = r;
    stored_total = stored_total + 1'b1;
  endtask

  // Update the ring for one accepted beat; a report queues the statistics it must return.
  task automatic apply_beat(input cmd_beat_t b);
    logic [TIME_W-1:0]   wall_span;
    logic [TIME_W+1:0]   cpu_triple;
    int unsigned         n;
    report_t             rep;
    wall_span = b.data.wall_now - b.data.wall_value;
    case (b.command)
      CMD_RECORD: store_sample(b.data.wall_value, b.data.cpu_value, b.data.reasons);
      CMD_END: begin
        if (wall_span >= {32'd0, threshold})
          store_sample(wall_span, b.data.cpu_now - b.data.cpu_value, b.data.reasons);
      end
      CMD_REPORT: begin
        rep = '0;
        n = (stored_total < RING_DEPTH) ? stored_total : RING_DEPTH;
        rep.analyzed = COUNT_OUT_W'(n);
        for (int i = 0; i < n; i++) begin
          rep.wall_sum = rep.wall_sum + ring_wall[i];
          rep.cpu_sum = rep.cpu_sum + ring_cpu[i];
          if (ring_wall[i] > rep.wall_max) rep.wall_max = ring_wall[i];
          if (ring_cpu[i] > rep.cpu_max) rep.cpu_max = ring_cpu[i];
          // compare in 66 bits so the triple never wraps
          cpu_triple = {2'b00, ring_cpu[i]} * 66'd3;
          if ({2'b00, ring_wall[i]} > cpu_triple) rep.preempted++;
          else rep.real_work++;
          if (ring_reason[i][0]) rep.lock_wait++;
          if (ring_reason[i][1]) rep.new_slab++;
          if (ring_reason[i][2]) rep.repair++;
          if (ring_reason[i][3]) rep.overflow++;
          if (ring_reason[i][4]) rep.retry++;
        end
        expected_reports.push_back(rep);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string fname, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : drive
    logic load;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_beat(cmd_beat_t'({s_tuser, s_tdata}));
        accepted_count++;
      end
      if (!s_tvalid || s_tready) begin
        load = (cmd_queue.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        if (load) begin
          s_tuser <= cmd_queue[0].command;
          s_tdata <= cmd_queue[0].data;
          cmd_queue.pop_front();
        end
        s_tvalid <= load;
      end
    end
  end

  always @(posedge clk) begin : watch
    report_t got;
    report_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = report_t'(m_tdata);
        if (expected_reports.size() == 0) begin
          $display("%0t: report beat with none expected, got %0h", $time, m_tdata);
          error_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("analyzed_count", want.analyzed, got.analyzed);
          check_field("preempted_count", want.preempted, got.preempted);
          check_field("real_work_count", want.real_work, got.real_work);
          check_field("wall_sum", want.wall_sum, got.wall_sum);
          check_field("cpu_sum", want.cpu_sum, got.cpu_sum);
          check_field("wall_max", want.wall_max, got.wall_max);
          check_field("cpu_max", want.cpu_max, got.cpu_max);
          check_field("lock_wait_count", want.lock_wait, got.lock_wait);
          check_field("new_slab_count", want.new_slab, got.new_slab);
          check_field("repair_count", want.repair, got.repair);
          check_field("overflow_count", want.overflow, got.overflow);
          check_field("retry_count", want.retry, got.retry);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // skew toward both ends of the range so sums and maxima see wrap and saturation
  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(5))
      0: return 64'($urandom_range(15));
      1: return TIME_ALL_ONES - 64'($urandom_range(15));
      2: return {32'd0, $urandom};
      default: return rand64();
    endcase
  endfunction

  function automatic cmd_beat_t mk_beat(input logic [CMD_W-1:0] command,
                                        input logic [TIME_W-1:0] wv, input logic [TIME_W-1:0] cv,
                                        input logic [TIME_W-1:0] wn, input logic [TIME_W-1:0] cn,
                                        input logic [REASON_W-1:0] r);
    cmd_beat_t b;
    b = '0;
    b.command = command;
    b.data.wall_value = wv;
    b.data.cpu_value = cv;
    b.data.wall_now = wn;
    b.data.cpu_now = cn;
    b.data.reasons = r;
    return b;
  endfunction

  function automatic cmd_beat_t make_record();
    logic [TIME_W-1:0] w;
    logic [TIME_W-1:0] c;
    case ($urandom_range(3))
      0: begin
        // straddle the largest CPU time whose triple fits
        c = CPU_TRIPLE_LIMIT - 64'd1 + 64'($urandom_range(2));
        w = TIME_ALL_ONES - 64'($urandom_range(4));
      end
      1: begin
        c = pick_time();
        w = c * 64'd3 - 64'd1 + 64'($urandom_range(2));
      end
      default: begin
        c = pick_time();
        w = pick_time();
      end
    endcase
    return mk_beat(CMD_RECORD, w, c, rand64(), rand64(), REASON_W'($urandom_range(31)));
  endfunction

  function automatic cmd_beat_t make_end();
    logic [TIME_W-1:0] wv;
    logic [TIME_W-1:0] cv;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] cpu_delta;
    wv = pick_time();
    cv = pick_time();
    case ($urandom_range(3))
      0: elapsed = {32'd0, threshold} - 64'd1 + 64'($urandom_range(2));
      1: elapsed = {32'd0, $urandom};
      2: elapsed = rand64();
      default: elapsed = 64'($urandom_range(200000));
    endcase
    case ($urandom_range(2))
      0: cpu_delta = elapsed / 64'(1 + $urandom_range(4));
      1: cpu_delta = elapsed / 64'd3 + 64'($urandom_range(1));
      default: cpu_delta = pick_time();
    endcase
    return mk_beat(CMD_END, wv, cv, wv + elapsed, cv + cpu_delta,
                   REASON_W'($urandom_range(31)));
  endfunction

  task automatic push_beat(input cmd_beat_t b);
    cmd_queue.push_back(b);
    pushed_count++;
  endtask

  task automatic wait_drained();
    while (accepted_count != pushed_count || expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THRESH_W-1:0] v);
    wait_drained();
    repeat (16) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    threshold = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_random(input int unsigned count);
    int unsigned done;
    int unsigned pick;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 45) push_beat(make_record());
      else if (pick < 90) push_beat(make_end());
      else if (pick < 95) push_beat(mk_beat(CMD_REPORT, rand64(), rand64(), rand64(),
                                             rand64(), REASON_W'($urandom_range(31))));
      else push_beat(mk_beat(CMD_UNUSED, rand64(), rand64(), rand64(), rand64(),
                             REASON_W'($urandom_range(31))));
      // ignored beats do not count toward the batch
      if (pick < 95) done++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 6;
    recv_stall_pct = 51;

    // empty ring, then the ignored command
    push_beat(mk_beat(CMD_REPORT, '0, '0, '0, '0, '0));
    push_beat(mk_beat(CMD_UNUSED, rand64(), rand64(), rand64(), rand64(), 5'h1f));
    push_beat(mk_beat(CMD_RECORD, '0, '0, '0, '0, 5'h00));
    push_beat(mk_beat(CMD_RECORD, TIME_ALL_ONES, TIME_ALL_ONES, '0, '0, 5'h1f));
    // preemption edges around the largest CPU time whose triple fits
    push_beat(mk_beat(CMD_RECORD, TIME_ALL_ONES, CPU_TRIPLE_LIMIT, '0, '0, 5'h01));
    push_beat(mk_beat(CMD_RECORD, TIME_ALL_ONES, CPU_TRIPLE_LIMIT - 64'd1, '0, '0, 5'h02));
    push_beat(mk_beat(CMD_RECORD, TIME_ALL_ONES, CPU_TRIPLE_LIMIT + 64'd1, '0, '0, 5'h04));
    push_beat(mk_beat(CMD_RECORD, 64'd3, 64'd1, '0, '0, 5'h08));
    push_beat(mk_beat(CMD_RECORD, 64'd4, 64'd1, '0, '0, 5'h10));
    // end beats just under, exactly at (across a wrap) and far above the threshold
    push_beat(mk_beat(CMD_END, 64'd1000, 64'd7, 64'd1000 + THRESHOLD_RESET - 64'd1,
                      64'd9, 5'h03));
    push_beat(mk_beat(CMD_END, TIME_ALL_ONES - 64'd10, TIME_ALL_ONES,
                      TIME_ALL_ONES - 64'd10 + THRESHOLD_RESET, 64'd5, 5'h0c));
    push_beat(mk_beat(CMD_END, '0, '0, TIME_ALL_ONES, 64'd1, 5'h11));
    push_beat(mk_beat(CMD_REPORT, '0, '0, '0, '0, '0));
    push_beat(mk_beat(CMD_UNUSED, '0, '0, '0, '0, '0));
    push_beat(mk_beat(CMD_REPORT, rand64(), rand64(), rand64(), rand64(), 5'h1f));

    write_threshold('0);
    push_random(ITEMS_PER_PHASE);

    write_threshold('1);
    send_idle_pct = 51;
    recv_stall_pct = 6;
    push_random(ITEMS_PER_PHASE);

    write_threshold($urandom);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_random(ITEMS_PER_PHASE / 2);
    write_threshold(THRESHOLD_RESET);
    push_random(ITEMS_PER_PHASE / 2);

    wait_drained();
    repeat (WALK_SETTLE) @(posedge clk);
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("tb_latency_sample_ring_monitor_unit: clean");
    end else begin
      $display("tb_latency_sample_ring_monitor_unit: errors");
    end
    $finish;
  end

endmodule
